// File: rtl/tsd_pkg.sv
// Package with the phase type, status codes and result record of the TLV stream deframer.
package tsd_pkg;

    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT_HI = 3'd2,
        PH_EXT_LO = 3'd3,
        PH_VALUE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALUE_BYTE  = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_TRUNC_HDR   = 2'd2,
        ST_TRUNC_VALUE = 2'd3
    } status_t;

    localparam logic [7:0] EXT_MARK = 8'hFF;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic        carries_byte;
        logic [7:0]  record_type;
        logic [15:0] record_length;
        logic        extended_format;
        logic [7:0]  value_byte;
        logic [15:0] byte_offset;
        logic        last_of_record;
    } result_t;

endpackage

// File: rtl/tlv_stream_deframer_unit.sv
// Top level of the TLV stream deframer with its input and result registers.
// The input stream carries one buffer byte per transaction in s_tdata, with s_tlast
// set on the buffer's final byte. Each record is a type byte, a length byte and,
// when the length byte is 0xFF, a 16-bit big-endian extended length.
// The result stream gives one transaction per value byte, one for an empty record
// and one for a buffer that ends in a header; other header bytes give none, and a
// value cut short is marked on its last byte. m_tuser holds the status and a flag
// that says whether the value byte is present; m_tlast marks the final transaction
// of a record. An accepted byte passes through the input register and then the
// result register, with the parser between them; the parser handles one byte per
// cycle, so a transaction can be accepted in every cycle while the result side
// keeps up.
// Reset empties both registers and returns the parser to expecting a type byte.
// When the receiver stalls, the held result stays put, one further byte waits in
// the input register, and s_tready then drops until the result is taken.
module tlv_stream_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // record_type [7:0], record_length [23:8],
                                   // extended_format [24], value_byte [32:25],
                                   // byte_offset [48:33], zero fill [55:49]
    output logic [2:0]  m_tuser,   // status [1:0], carries_byte [2]
    output logic        m_tlast
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;
    logic        out_valid_reg, out_valid_next;
    tsd_pkg::result_t out_reg;
    tsd_pkg::result_t result;
    logic        advance;
    logic        fire;
    logic        s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    tsd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (fire),
        .data_byte     (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .result        (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
        end
        if (advance && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.byte_offset, out_reg.value_byte,
                       out_reg.extended_format, out_reg.record_length, out_reg.record_type};
    assign m_tuser  = {out_reg.carries_byte, out_reg.status};
    assign m_tlast  = out_reg.last_of_record;

    a_value_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == tsd_pkg::ST_VALUE_BYTE) |-> m_tuser[2])
        else $error("value byte result without a value byte");

    a_empty_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == tsd_pkg::ST_EMPTY) |->
        (m_tlast && !m_tuser[2] && m_tdata[23:8] == 16'd0))
        else $error("malformed empty record result");

    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == tsd_pkg::ST_TRUNC_HDR ||
                      m_tuser[1:0] == tsd_pkg::ST_TRUNC_VALUE)) |-> m_tlast)
        else $error("truncation result not marked last");

    a_offset_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tdata[48:33] < m_tdata[23:8]))
        else $error("value byte offset beyond declared length");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled without a pending transaction");

endmodule

// File: rtl/tsd_parser.sv
// Record parser of the TLV stream deframer: header state machine and value byte tagging.
module tsd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    output tsd_pkg::result_t  result
);

    tsd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        is_extended_reg, is_extended_next;

    logic [15:0] len_done;
    logic [15:0] left_dec;

    always_comb begin
        case (phase_reg)
            tsd_pkg::PH_LEN: len_done = {8'h00, data_byte};
            default:         len_done = {held_length_reg[15:8], data_byte};
        endcase
    end

    assign left_dec = bytes_left_reg - 16'd1;

    // Next state.
    always_comb begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        bytes_left_next  = bytes_left_reg;
        is_extended_next = is_extended_reg;
        if (step) begin
            case (phase_reg)
                tsd_pkg::PH_LEN: begin
                    if (data_byte == tsd_pkg::EXT_MARK) begin
                        is_extended_next = 1'b1;
                        held_length_next = 16'd0;
                        phase_next = end_of_buffer ? tsd_pkg::PH_TYPE : tsd_pkg::PH_EXT_HI;
                    end else begin
                        is_extended_next = 1'b0;
                        held_length_next = len_done;
                        bytes_left_next  = len_done;
                        phase_next = (len_done == 16'd0 || end_of_buffer) ?
                                     tsd_pkg::PH_TYPE : tsd_pkg::PH_VALUE;
                    end
                end
                tsd_pkg::PH_EXT_HI: begin
                    held_length_next = {data_byte, 8'h00};
                    phase_next = end_of_buffer ? tsd_pkg::PH_TYPE : tsd_pkg::PH_EXT_LO;
                end
                tsd_pkg::PH_EXT_LO: begin
                    held_length_next = len_done;
                    bytes_left_next  = len_done;
                    phase_next = (len_done == 16'd0 || end_of_buffer) ?
                                 tsd_pkg::PH_TYPE : tsd_pkg::PH_VALUE;
                end
                tsd_pkg::PH_VALUE: begin
                    if (left_dec == 16'd0 || end_of_buffer) begin
                        bytes_left_next = 16'd0;
                        phase_next = tsd_pkg::PH_TYPE;
                    end else begin
                        bytes_left_next = left_dec;
                    end
                end
                default: begin
                    held_type_next   = data_byte;
                    held_length_next = 16'd0;
                    bytes_left_next  = 16'd0;
                    is_extended_next = 1'b0;
                    phase_next = end_of_buffer ? tsd_pkg::PH_TYPE : tsd_pkg::PH_LEN;
                end
            endcase
        end
    end

    // Result of the current byte.
    always_comb begin
        result                 = '0;
        result.record_type     = held_type_reg;
        result.extended_format = is_extended_reg;
        result.status          = tsd_pkg::ST_VALUE_BYTE;
        case (phase_reg)
            tsd_pkg::PH_LEN: begin
                if (data_byte == tsd_pkg::EXT_MARK) begin
                    result.extended_format = 1'b1;
                    result.valid          = end_of_buffer;
                    result.status         = tsd_pkg::ST_TRUNC_HDR;
                    result.last_of_record = 1'b1;
                end else begin
                    result.extended_format = 1'b0;
                    result.valid          = (len_done == 16'd0) || end_of_buffer;
                    result.status         = (len_done == 16'd0) ? tsd_pkg::ST_EMPTY
                                                                : tsd_pkg::ST_TRUNC_VALUE;
                    result.record_length  = len_done;
                    result.last_of_record = 1'b1;
                end
            end
            tsd_pkg::PH_EXT_HI: begin
                result.valid          = end_of_buffer;
                result.status         = tsd_pkg::ST_TRUNC_HDR;
                result.last_of_record = 1'b1;
            end
            tsd_pkg::PH_EXT_LO: begin
                result.valid          = (len_done == 16'd0) || end_of_buffer;
                result.status         = (len_done == 16'd0) ? tsd_pkg::ST_EMPTY
                                                            : tsd_pkg::ST_TRUNC_VALUE;
                result.record_length  = len_done;
                result.last_of_record = 1'b1;
            end
            tsd_pkg::PH_VALUE: begin
                result.valid          = 1'b1;
                result.carries_byte   = 1'b1;
                result.record_length  = held_length_reg;
                result.value_byte     = data_byte;
                result.byte_offset    = held_length_reg - bytes_left_reg;
                result.last_of_record = (left_dec == 16'd0) || end_of_buffer;
                result.status         = (left_dec != 16'd0 && end_of_buffer) ?
                                        tsd_pkg::ST_TRUNC_VALUE : tsd_pkg::ST_VALUE_BYTE;
            end
            default: begin
                result.record_type    = data_byte;
                result.extended_format = 1'b0;
                result.valid          = end_of_buffer;
                result.status         = tsd_pkg::ST_TRUNC_HDR;
                result.last_of_record = 1'b1;
            end
        endcase
        if (!step) begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= tsd_pkg::PH_TYPE;
            held_type_reg   <= 8'd0;
            held_length_reg <= 16'd0;
            bytes_left_reg  <= 16'd0;
            is_extended_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            bytes_left_reg  <= bytes_left_next;
            is_extended_reg <= is_extended_next;
        end
    end

endmodule
